@@ hw/rtl/rk4_pkg.sv @@
// rk4_pkg: shared types and constants for the rk4 ode step unit
// no dependencies
package rk4_pkg;

  localparam int unsigned XW = 32;
  localparam int unsigned CW = 16;
  localparam int unsigned HW = 31;
  localparam int unsigned AW = 36;     // q30 angle width
  localparam int unsigned SW = 34;     // cordic x/y width

  localparam logic signed [AW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [AW-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [AW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [SW-1:0] Q30_INV_GAIN = 34'sd652032874;
  localparam logic signed [47:0] I32_MAX_V = 48'sd2147483647;
  localparam logic signed [47:0] I32_MIN_V = -48'sd2147483648;

  // register indexes
  typedef enum logic [1:0] {
    REG_STEP_SIZE = 2'd0,
    REG_X_START   = 2'd1,
    REG_Y_START   = 2'd2,
    REG_MAX_STEPS = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_RED, ST_CORD, ST_KVAL, ST_YARG, ST_SUM, ST_DIV,
    ST_YNEW, ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;      // latch item, apply restart
    logic       red;       // angle reduction step
    logic       cord;      // one cordic iteration
    logic       kval;      // form k from sine
    logic       yarg;      // form next y argument
    logic       sum;       // form weighted sum
    logic       div;       // one step of divide by 6
    logic       ynew;      // commit new state
    logic [1:0] kidx;      // which k (0..3)
  } rk4_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic limit;      // step counter reached max
    logic red_done;
    logic cord_done;
    logic div_done;
  } rk4_sts_t;

  function automatic logic [63:0] atan_q30(input logic [4:0] i);
    logic [31:0] t [0:31];
    t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
          32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
          32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
          32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
          32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
          32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
          32'h00000001, 32'h00000000};
    return {32'd0, t[i]};
  endfunction

endpackage

@@ hw/rtl/rk4_if.sv @@
// rk4_if: valid/ready channel interfaces for input, result and config words
// depends on nothing
interface rk4_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface rk4_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic [15:0]        steps_done;
  logic               done_flag;
  logic               overflow_flag;
  modport source (output valid, output x_value, output y_value, output steps_done,
                  output done_flag, output overflow_flag, input ready);
  modport sink (input valid, input x_value, input y_value, input steps_done,
                input done_flag, input overflow_flag, output ready);
endinterface

interface rk4_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/rk4_ctrl.sv @@
// rk4_ctrl: sequencer for one rk4 step (four sine evaluations and updates)
// depends on rk4_pkg
module rk4_ctrl
  import rk4_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_busy,
  input  rk4_sts_t sts,
  output rk4_cmd_t cmd,
  output logic     busy,
  output logic     out_set
);

  state_t     state_r, state_nxt;
  logic [1:0] kidx_r, kidx_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kidx_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    kidx_nxt  = kidx_r;
    cmd       = '0;
    cmd.kidx  = kidx_r;
    out_set   = 1'b0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        kidx_nxt  = 2'd0;
        state_nxt = sts.limit ? ST_OUT : ST_RED;
      end
      ST_RED: begin
        cmd.red = 1'b1;
        if (sts.red_done) state_nxt = ST_CORD;
      end
      ST_CORD: begin
        cmd.cord = 1'b1;
        if (sts.cord_done) state_nxt = ST_KVAL;
      end
      ST_KVAL: begin
        cmd.kval  = 1'b1;
        state_nxt = (kidx_r == 2'd3) ? ST_SUM : ST_YARG;
      end
      ST_YARG: begin
        cmd.yarg  = 1'b1;
        kidx_nxt  = kidx_r + 2'd1;
        state_nxt = ST_RED;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_done) state_nxt = ST_YNEW;
      end
      ST_YNEW: begin
        cmd.ynew  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) begin
          out_set   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/rk4_dp.sv @@
// rk4_dp: state registers, angle reduction, shared cordic, multiplier and divider
// depends on rk4_pkg
module rk4_dp
  import rk4_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rk4_cmd_t           cmd,
  input  logic               in_restart,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output rk4_sts_t           sts,
  output logic signed [31:0] x_cur,
  output logic signed [31:0] y_cur,
  output logic [CW-1:0]      cnt_cur,
  output logic               done_o,
  output logic               ov_o
);

  localparam int NIT = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;
  localparam int SH  = 30 - FRAC_BITS;
  // largest 2pi multiple that still fits the 48-bit angle
  localparam logic [3:0] RED_TOP = 4'd14;
  // ceil(2^22 / 6), exact for dividends below 2^21
  localparam logic [41:0] DIV6_RECIP = 42'd699051;

  logic [HW-1:0]        h_r;
  logic signed [31:0]   xs_r, ys_r, x_r, y_r, yb_r, ya_r;
  logic [CW-1:0]        maxs_r, cnt_r;
  logic signed [31:0]   k_r;
  logic signed [35:0]   sum_r;
  logic signed [AW-1:0] ang_r;
  logic signed [SW-1:0] cx_r, cy_r;
  logic [4:0]           it_r;
  logic                 ov_r, done_r;
  logic [33:0]          dn_r;
  logic [14:0]          dqh_r;
  logic [19:0]          dt_r;
  logic [1:0]           dph_r;
  logic                 dneg_r;
  logic signed [31:0]   acc2_r;

  // divide by 6 by reciprocal multiply, input below 2^20
  function automatic logic [16:0] div6(input logic [19:0] v);
    logic [41:0] p;
    p = {22'd0, v} * DIV6_RECIP;
    return p[38:22];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r    <= 31'd6554;
      xs_r   <= 32'sd0;
      ys_r   <= 32'sd655360;
      maxs_r <= 16'd100;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEP_SIZE: h_r    <= cfg_data[HW-1:0];
        REG_X_START:   xs_r   <= cfg_data;
        REG_Y_START:   ys_r   <= cfg_data;
        REG_MAX_STEPS: maxs_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // sine argument per k: x, x+h/2, x+h/2, x+h in q30
  logic signed [47:0] x0q, arg;
  always_comb begin
    x0q = 48'(x_r) <<< SH;
    unique case (cmd.kidx)
      2'd0:    arg = x0q;
      2'd3:    arg = x0q + (48'({1'b0, h_r}) <<< SH);
      default: arg = x0q + (48'({1'b0, h_r}) <<< (SH - 1));
    endcase
  end

  // reduction: fold to [0, 2pi) by repeated add/subtract of 2pi<<j, then map to [-pi/2, pi/2]
  logic signed [47:0] red_r;
  logic [3:0]         rj_r;
  logic               rphase_r;
  logic signed [47:0] tp_sh, red_try;
  logic signed [AW-1:0] r_m;
  always_comb begin
    tp_sh   = 48'(Q30_TWO_PI) <<< rj_r;
    red_try = red_r[47] ? red_r + tp_sh : red_r - tp_sh;
    r_m     = red_r[AW-1:0];
    if (r_m > Q30_PI) r_m = r_m - Q30_TWO_PI;
    if (r_m > Q30_HALF_PI) r_m = Q30_PI - r_m;
    else if (r_m < -Q30_HALF_PI) r_m = -Q30_PI - r_m;
  end
  assign sts.red_done = rphase_r && (rj_r == 4'd0) && !red_r[47] &&
                        (red_r < 48'(Q30_TWO_PI));

  // cordic step
  logic signed [SW-1:0] dx, dy;
  logic [63:0]          atan_w;
  assign dx = cy_r >>> it_r;
  assign dy = cx_r >>> it_r;
  assign atan_w = atan_q30(it_r);
  assign sts.cord_done = (32'(it_r) >= NIT - 1) || (NIT == 0);

  // sine result with rounding and clamp
  logic signed [SW-1:0] s_rnd;
  logic signed [31:0]   s_q;
  always_comb begin
    s_rnd = (cy_r + (SW'(1) <<< (SH - 1))) >>> SH;
    if (s_rnd > (SW'(1) <<< FRAC_BITS)) s_q = 32'sd1 <<< FRAC_BITS;
    else if (s_rnd < -(SW'(1) <<< FRAC_BITS)) s_q = -(32'sd1 <<< FRAC_BITS);
    else s_q = s_rnd[31:0];
  end

  // k = sat(sin - y_arg)
  logic signed [32:0] kd;
  logic signed [31:0] kv;
  logic               kov;
  always_comb begin
    kd  = 33'(s_q) - 33'(ya_r);
    kov = (kd[32] != kd[31]);
    kv  = kov ? (kd[32] ? 32'h80000000 : 32'h7FFFFFFF) : kd[31:0];
  end

  // shared multiplier h*k or h*(sum/6) (31x32) and y update
  logic signed [31:0] mop;
  logic signed [63:0] prod;
  logic [5:0]         msh;
  logic signed [63:0] prnd;
  logic signed [47:0] ysum;
  logic signed [31:0] ysat;
  logic               yov;
  always_comb begin
    mop  = cmd.ynew ? acc2_r : k_r;
    prod = $signed({1'b0, h_r}) * mop;
    msh  = (cmd.yarg && cmd.kidx != 2'd2) ? 6'(FRAC_BITS + 1) : 6'(FRAC_BITS);
    prnd = (prod + (64'sd1 <<< (msh - 1))) >>> msh;
    ysum = 48'(yb_r) + prnd[47:0];
    yov  = (ysum > I32_MAX_V) || (ysum < I32_MIN_V);
    ysat = (ysum > I32_MAX_V) ? 32'h7FFFFFFF :
           (ysum < I32_MIN_V) ? 32'h80000000 : ysum[31:0];
  end

  // x update
  logic signed [32:0] xsum;
  logic signed [31:0] xsat;
  logic               xov;
  always_comb begin
    xsum = 33'(x_r) + 33'({1'b0, h_r});
    xov  = xsum[32] != xsum[31];
    xsat = xov ? 32'h7FFFFFFF : xsum[31:0];
  end

  // weighted sum plus 3, magnitude for floor division
  logic signed [35:0] sum3;
  logic [35:0]        sum_mag;
  always_comb begin
    sum3    = sum_r + 36'sd3;
    sum_mag = (sum3 < 0) ? 36'(-sum3 + 36'sd5) : 36'(sum3);
  end

  // divide by 6 in three steps: upper 17 bits, remainder, lower part
  logic [19:0]        d6_in;
  logic [16:0]        d6_q;
  logic [2:0]         dr_hi;
  logic [32:0]        dq_all;
  logic signed [32:0] qv;
  always_comb begin
    d6_in  = (dph_r == 2'd0) ? {3'd0, dn_r[33:17]} : dt_r;
    d6_q   = div6(d6_in);
    dr_hi  = 3'(dn_r[33:17] - ({2'd0, dqh_r} * 17'd6));
    dq_all = {1'b0, dqh_r, 17'd0} + {16'd0, d6_q};
    qv     = dneg_r ? -$signed(dq_all) : $signed(dq_all);
  end
  assign sts.div_done = (dph_r == 2'd2);

  assign sts.limit = (cnt_r >= maxs_r);

  // main datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= 32'sd0; y_r <= 32'sd655360; cnt_r <= '0;
      ov_r <= 1'b0; done_r <= 1'b0; rphase_r <= 1'b0; rj_r <= '0;
      it_r <= '0; dph_r <= '0;
    end else begin
      if (cmd.load) begin
        if (in_restart) begin
          x_r <= xs_r; y_r <= ys_r; cnt_r <= '0;
          yb_r <= ys_r; ya_r <= ys_r;
          done_r <= (maxs_r == 16'd0);
        end else begin
          yb_r <= y_r; ya_r <= y_r;
          done_r <= (cnt_r >= maxs_r);
        end
        ov_r <= 1'b0; rphase_r <= 1'b0; rj_r <= RED_TOP;
        red_r <= 48'(arg);
        sum_r <= '0;
      end
      if (cmd.red) begin
        if (!rphase_r) begin
          red_r <= arg; rphase_r <= 1'b1; rj_r <= RED_TOP;
        end else if (!sts.red_done) begin
          if (red_r[47] || red_r >= tp_sh) red_r <= red_try;
          else if (rj_r != 4'd0) rj_r <= rj_r - 4'd1;
        end else begin
          ang_r <= r_m; cx_r <= Q30_INV_GAIN; cy_r <= '0; it_r <= '0;
          rphase_r <= 1'b0;
        end
      end
      if (cmd.cord) begin
        if (ang_r >= 0) begin
          cx_r <= cx_r - dx; cy_r <= cy_r + dy;
          ang_r <= ang_r - $signed(atan_w[AW-1:0]);
        end else begin
          cx_r <= cx_r + dx; cy_r <= cy_r - dy;
          ang_r <= ang_r + $signed(atan_w[AW-1:0]);
        end
        it_r <= sts.cord_done ? 5'd0 : it_r + 5'd1;
      end
      if (cmd.kval) begin
        k_r <= kv;
        if (kov) ov_r <= 1'b1;
        sum_r <= sum_r + ((cmd.kidx == 2'd1 || cmd.kidx == 2'd2) ?
                          (36'(kv) <<< 1) : 36'(kv));
      end
      if (cmd.yarg) begin
        ya_r <= ysat;
        if (yov) ov_r <= 1'b1;
      end
      if (cmd.sum) begin
        dneg_r <= (sum3 < 0);
        dn_r   <= sum_mag[33:0];
        dph_r  <= 2'd0;
      end
      if (cmd.div) begin
        if (dph_r == 2'd0) dqh_r <= d6_q[14:0];
        if (dph_r == 2'd1) dt_r <= {dr_hi, dn_r[16:0]};
        if (dph_r == 2'd2) acc2_r <= qv[31:0];
        else dph_r <= dph_r + 2'd1;
      end
      if (cmd.ynew) begin
        y_r <= ysat; x_r <= xsat; cnt_r <= cnt_r + 1'b1;
        if (yov || xov) ov_r <= 1'b1;
      end
    end
  end

  assign x_cur   = x_r;
  assign y_cur   = y_r;
  assign cnt_cur = cnt_r;
  assign done_o  = done_r;
  assign ov_o    = ov_r;

endmodule

@@ hw/rtl/rk4_ode_step_unit.sv @@
// rk4_ode_step_unit: top level, joins controller, datapath and result register
// depends on rk4_pkg, rk4_if, rk4_ctrl, rk4_dp
//
// One input word advances the kept (x, y) by one rk4 step of y' = sin(x) - y
// in signed q16.16, unless the step limit is reached, and returns one result
// word. A step runs four sine evaluations, each an angle reduction followed by
// CORDIC iterations, on the one shared CORDIC unit, and then a divide by six.
// A word that finds the step limit reached returns without a step. Items are
// taken one at a time; a new word may be taken while the previous result waits
// in the output register. Config writes are accepted at any time but belong in
// idle periods.
module rk4_ode_step_unit
  import rk4_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input logic clk,
  input logic rst_n,
  rk4_in_if.sink    in_ch,
  rk4_out_if.source out_ch,
  rk4_cfg_if.sink   cfg_ch
);

  rk4_cmd_t           cmd;
  rk4_sts_t           sts;
  logic               busy, out_set, in_fire;
  logic               out_valid_r;
  logic signed [31:0] x_cur, y_cur;
  logic [CW-1:0]      cnt_cur;
  logic               done_w, ov_w;

  assign in_ch.ready  = !busy;
  assign in_fire      = in_ch.valid && !busy;
  assign cfg_ch.ready = 1'b1;

  rk4_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_busy(out_valid_r && !out_ch.ready),
    .sts(sts), .cmd(cmd), .busy(busy), .out_set(out_set)
  );

  rk4_dp #(.FRAC_BITS(FRAC_BITS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_restart(in_ch.restart),
    .cfg_we(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
    .sts(sts), .x_cur(x_cur), .y_cur(y_cur), .cnt_cur(cnt_cur),
    .done_o(done_w), .ov_o(ov_w)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_set) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_set) begin
      out_ch.x_value       <= x_cur;
      out_ch.y_value       <= y_cur;
      out_ch.steps_done    <= cnt_cur;
      out_ch.done_flag     <= done_w;
      out_ch.overflow_flag <= ov_w;
    end
  end
  assign out_ch.valid = out_valid_r;

endmodule

@@ hw/rtl/rk4_chk.sv @@
// rk4_chk: port-level checks for rk4_ode_step_unit, bound to the top level
// depends on rk4_ode_step_unit and its rk4_if ports
module rk4_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_done_flag,
  input logic out_overflow_flag
);

  // result flags held under stall
  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_done_flag) && $stable(out_overflow_flag)))
    else $error("result flags changed while stalled");

  // result valid held under stall
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");

  // a limit result shows no overflow
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_done_flag && out_overflow_flag))
    else $error("done and overflow together");

  // a taken word drops ready
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after accept");

endmodule

bind rk4_ode_step_unit rk4_chk u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_done_flag(out_ch.done_flag), .out_overflow_flag(out_ch.overflow_flag)
);
